/* rtl/ptd_pkg.sv */
package ptd_pkg;

	localparam int NUM_TASKS = 6;
	localparam int IDX_W = 3;
	localparam int TIME_W = 32;
	localparam int IVL_W = 20;
	localparam int MASK_W = 6;
	localparam int CFG_IDX_W = 3;

	localparam logic [1:0] OP_INIT = 2'd0;
	localparam logic [1:0] OP_START = 2'd1;
	localparam logic [1:0] OP_DONE = 2'd2;

	localparam logic [1:0] KIND_DISPATCH = 2'd0;
	localparam logic [1:0] KIND_DONE = 2'd1;
	localparam logic [1:0] KIND_REJECT = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_BUDGET = 3'd7;

	localparam logic [MASK_W-1:0] ENABLE_RESET = 6'd63;
	localparam logic [IVL_W-1:0] BUDGET_RESET = 20'd500;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TASKS - 1);

	typedef struct packed {
		logic vld;
		logic [IDX_W-1:0] off;
	} ptd_tok_t;

	typedef struct packed {
		logic hit;
		logic miss;
		logic [IDX_W-1:0] idx;
		logic [IDX_W-1:0] off;
	} ptd_rep_t;

	typedef struct packed {
		logic [TIME_W-1:0] now;
		logic [TIME_W-1:0] stamp_time;
		logic stamp_all;
		logic stamp_one;
		logic [IDX_W-1:0] stamp_idx;
		logic inject;
		logic [IDX_W-1:0] inj_idx;
		logic [IDX_W-1:0] inj_off;
	} ptd_ctl_t;

	function automatic logic [IVL_W-1:0] interval_reset(input logic [IDX_W-1:0] idx);
		logic [IVL_W-1:0] v;
		case (idx)
			3'd0: v = 20'd125;
			3'd1: v = 20'd1000;
			3'd2: v = 20'd1000;
			3'd3: v = 20'd1000;
			3'd4: v = 20'd16666;
			3'd5: v = 20'd2000;
			default: v = '0;
		endcase
		return v;
	endfunction

	function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx);
		logic [IDX_W-1:0] v;
		if (idx == LAST_IDX) begin
			v = '0;
		end else begin
			v = idx + 1'b1;
		end
		return v;
	endfunction

endpackage

/* rtl/periodic_task_dispatcher_core.sv */
// Init, rejected opcodes, budget-ended passes and a task_done at the last scan position give
// their result in the cycle after the transaction is accepted. A scan moves a token one task
// cell per cycle, so the wait for a dispatch or a pass end found by scanning grows with the
// number of task cells that the token passes.
// One item is worked on at a time, so the input is not ready while an item is in work; the next
// is taken at the earliest in the cycle in which the result of the previous one is accepted.
// Reset clears all last-run times and control state and restores register defaults.
module periodic_task_dispatcher_core import ptd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [31:0] s_tdata, // time_us
	input  logic [1:0] s_tuser, // opcode
	output logic m_tvalid,
	input  logic m_tready,
	output logic [7:0] m_tdata, // task_index, budget_spent, zero fill
	output logic [1:0] m_tuser, // kind
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [IVL_W-1:0] cfg_data
);

	logic [MASK_W-1:0] enable_q;
	logic [IVL_W-1:0] budget_q;
	logic cfg_we;
	ptd_ctl_t ctl;
	ptd_tok_t tok [NUM_TASKS];
	ptd_rep_t rep [NUM_TASKS];
	ptd_rep_t agg;
	logic [IDX_W-1:0] m_task;
	logic m_spent;

	assign cfg_ready = 1'b1;
	assign cfg_we = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= ENABLE_RESET;
			budget_q <= BUDGET_RESET;
		end else if (cfg_we) begin
			if (cfg_index == CFG_ENABLE) begin
				enable_q <= cfg_data[MASK_W-1:0];
			end
			if (cfg_index == CFG_BUDGET) begin
				budget_q <= cfg_data;
			end
		end
	end

	for (genvar i = 0; i < NUM_TASKS; i++) begin : g_cell
		ptd_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cell_idx (IDX_W'(i)),
			.ctl      (ctl),
			.en       (enable_q[i]),
			.int_we   (cfg_we && cfg_index == CFG_IDX_W'(i)),
			.int_data (cfg_data),
			.tok_in   (tok[(i + NUM_TASKS - 1) % NUM_TASKS]),
			.tok_out  (tok[i]),
			.rep      (rep[i])
		);
	end

	always_comb begin
		agg = '0;
		for (int i = 0; i < NUM_TASKS; i++) begin
			agg = agg | rep[i] & {$bits(ptd_rep_t){rep[i].hit || rep[i].miss}};
		end
	end

	ptd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_task   (m_task),
		.m_spent  (m_spent),
		.m_kind   (m_tuser),
		.budget   (budget_q),
		.agg      (agg),
		.ctl      (ctl)
	);

	assign m_tdata = {4'b0000, m_spent, m_task};

endmodule

/* rtl/ptd_cell.sv */
module ptd_cell import ptd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic [IDX_W-1:0] cell_idx,
	input  ptd_ctl_t ctl,
	input  logic en,
	input  logic int_we,
	input  logic [IVL_W-1:0] int_data,
	input  ptd_tok_t tok_in,
	output ptd_tok_t tok_out,
	output ptd_rep_t rep
);

	logic [TIME_W-1:0] last_q;
	logic [IVL_W-1:0] interval_q;
	ptd_tok_t tok_q;
	logic [TIME_W-1:0] elapsed;
	logic due;
	logic hit;
	logic miss;

	assign elapsed = ctl.now - last_q;
	assign due = elapsed >= {{(TIME_W-IVL_W){1'b0}}, interval_q};
	assign hit = tok_q.vld && en && due;
	assign miss = tok_q.vld && !hit && (tok_q.off == LAST_IDX);

	assign tok_out.vld = tok_q.vld && !hit && !miss;
	assign tok_out.off = tok_q.off + 1'b1;

	assign rep.hit = hit;
	assign rep.miss = miss;
	assign rep.idx = cell_idx;
	assign rep.off = tok_q.off;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
			interval_q <= interval_reset(cell_idx);
			tok_q <= '0;
		end else begin
			if (ctl.stamp_all || (ctl.stamp_one && ctl.stamp_idx == cell_idx)) begin
				last_q <= ctl.stamp_time;
			end
			if (int_we) begin
				interval_q <= int_data;
			end
			if (ctl.inject && ctl.inj_idx == cell_idx) begin
				tok_q.vld <= 1'b1;
				tok_q.off <= ctl.inj_off;
			end else begin
				tok_q <= tok_in;
			end
		end
	end

endmodule

/* rtl/ptd_ctrl.sv */
module ptd_ctrl import ptd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [TIME_W-1:0] s_tdata,
	input  logic [1:0] s_tuser,
	output logic m_tvalid,
	input  logic m_tready,
	output logic [IDX_W-1:0] m_task,
	output logic m_spent,
	output logic [1:0] m_kind,
	input  logic [IVL_W-1:0] budget,
	input  ptd_rep_t agg,
	output ptd_ctl_t ctl
);

	typedef enum logic [0:0] {ST_IDLE, ST_SCAN} state_t;

	state_t state_q;
	logic [TIME_W-1:0] now_q;
	logic [TIME_W-1:0] pass_start_q;
	logic [IDX_W-1:0] rr_q;
	logic [IDX_W-1:0] scan_off_q;
	logic [IDX_W-1:0] running_q;
	logic pass_active_q;
	logic out_valid_q;
	logic [1:0] kind_q;
	logic [IDX_W-1:0] task_q;
	logic spent_q;

	logic acc;
	logic [TIME_W-1:0] pass_elapsed;
	logic spent;
	logic start_ok;
	logic done_ok;
	logic done_scan;

	assign s_tready = (state_q == ST_IDLE) && (!out_valid_q || m_tready);
	assign acc = s_tvalid && s_tready;
	assign pass_elapsed = s_tdata - pass_start_q;
	assign spent = pass_elapsed >= {{(TIME_W-IVL_W){1'b0}}, budget};
	assign start_ok = acc && s_tuser == OP_START && !pass_active_q;
	assign done_ok = acc && s_tuser == OP_DONE && pass_active_q;
	assign done_scan = done_ok && !spent && scan_off_q != LAST_IDX;

	always_comb begin
		ctl.now = now_q;
		ctl.stamp_time = s_tdata;
		ctl.stamp_all = acc && s_tuser == OP_INIT;
		ctl.stamp_one = done_ok;
		ctl.stamp_idx = running_q;
		ctl.inject = start_ok || done_scan;
		ctl.inj_idx = start_ok ? rr_q : ring_next(running_q);
		ctl.inj_off = start_ok ? '0 : scan_off_q + 1'b1;
	end

	assign m_tvalid = out_valid_q;
	assign m_kind = kind_q;
	assign m_task = task_q;
	assign m_spent = spent_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			now_q <= '0;
			pass_start_q <= '0;
			rr_q <= '0;
			scan_off_q <= '0;
			running_q <= '0;
			pass_active_q <= 1'b0;
			out_valid_q <= 1'b0;
			kind_q <= KIND_DONE;
			task_q <= '0;
			spent_q <= 1'b0;
		end else begin
			if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						now_q <= s_tdata;
						task_q <= '0;
						spent_q <= 1'b0;
						case (s_tuser)
							OP_INIT: begin
								rr_q <= '0;
								scan_off_q <= '0;
								running_q <= '0;
								pass_active_q <= 1'b0;
								out_valid_q <= 1'b1;
								kind_q <= KIND_DONE;
							end
							OP_START: begin
								if (pass_active_q) begin
									out_valid_q <= 1'b1;
									kind_q <= KIND_REJECT;
								end else begin
									pass_start_q <= s_tdata;
									state_q <= ST_SCAN;
								end
							end
							OP_DONE: begin
								if (!pass_active_q) begin
									out_valid_q <= 1'b1;
									kind_q <= KIND_REJECT;
								end else if (spent) begin
									rr_q <= ring_next(running_q);
									pass_active_q <= 1'b0;
									scan_off_q <= '0;
									running_q <= '0;
									out_valid_q <= 1'b1;
									kind_q <= KIND_DONE;
									spent_q <= 1'b1;
								end else if (scan_off_q == LAST_IDX) begin
									pass_active_q <= 1'b0;
									scan_off_q <= '0;
									running_q <= '0;
									out_valid_q <= 1'b1;
									kind_q <= KIND_DONE;
								end else begin
									state_q <= ST_SCAN;
								end
							end
							default: begin
								out_valid_q <= 1'b1;
								kind_q <= KIND_REJECT;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (agg.hit) begin
						pass_active_q <= 1'b1;
						running_q <= agg.idx;
						scan_off_q <= agg.off;
						out_valid_q <= 1'b1;
						kind_q <= KIND_DISPATCH;
						task_q <= agg.idx;
						state_q <= ST_IDLE;
					end else if (agg.miss) begin
						pass_active_q <= 1'b0;
						running_q <= '0;
						scan_off_q <= '0;
						out_valid_q <= 1'b1;
						kind_q <= KIND_DONE;
						task_q <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_hit_only_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(agg.hit || agg.miss) |-> state_q == ST_SCAN)
		else $error("scan report outside a scan");
	a_scan_ends_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && (agg.hit || agg.miss)) |=> (state_q == ST_IDLE && out_valid_q))
		else $error("scan finished without a result");
	a_running_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		pass_active_q |-> running_q <= LAST_IDX)
		else $error("running task out of range");
	a_rr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		rr_q <= LAST_IDX)
		else $error("round-robin start out of range");
	a_no_accept_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> !s_tready)
		else $error("input accepted during a scan");
`endif

endmodule

/* test/tb_periodic_task_dispatcher_core.sv */
`timescale 1ns / 1ps

module tb_periodic_task_dispatcher_core;
	import ptd_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0] kind;
		logic [IDX_W-1:0] task_id;
		logic spent;
	} verdict_t;

	logic clk;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [31:0] s_tdata = '0;
	logic [1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic [1:0] m_tuser;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [IVL_W-1:0] cfg_data = '0;

	periodic_task_dispatcher_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	logic [IVL_W-1:0] ivl_q [NUM_TASKS];
	logic [MASK_W-1:0] en_q;
	logic [IVL_W-1:0] budget_q;
	logic [TIME_W-1:0] stamp_q [NUM_TASKS];
	logic [TIME_W-1:0] pass_t0;
	int rr_base;
	int cur_off;
	int cur_task;
	bit in_pass;

	logic [IVL_W-1:0] plan_ivl [NUM_TASKS];
	logic [MASK_W-1:0] plan_mask;
	logic [IVL_W-1:0] plan_budget;

	verdict_t outcome_q [$];
	verdict_t want;
	logic [TIME_W-1:0] now_us = '0;
	bit jitter_on = 1'b1;
	int unsigned n_items = 0;
	int unsigned n_cfg = 0;
	int unsigned n_phases = 0;
	int unsigned n_dispatch = 0;
	int unsigned n_spent = 0;
	int unsigned n_reject = 0;
	int unsigned n_fail = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10ms;
		$display("*** FAILED ***");
		$finish;
	end

	function automatic verdict_t scan_tasks(input int first, input logic [TIME_W-1:0] t);
		verdict_t v;
		int idx;
		logic [TIME_W-1:0] gap;
		v = '0;
		for (int off = first; off < NUM_TASKS; off++) begin
			idx = (rr_base + off) % NUM_TASKS;
			gap = t - stamp_q[idx];
			if (en_q[idx] && gap >= {12'd0, ivl_q[idx]}) begin
				in_pass = 1'b1;
				cur_task = idx;
				cur_off = off;
				v.kind = KIND_DISPATCH;
				v.task_id = IDX_W'(idx);
				return v;
			end
		end
		in_pass = 1'b0;
		cur_off = 0;
		cur_task = 0;
		v.kind = KIND_DONE;
		return v;
	endfunction

	function automatic verdict_t predict_dispatch(input logic [1:0] op,
			input logic [TIME_W-1:0] t);
		verdict_t v;
		logic [TIME_W-1:0] used;
		v = '0;
		v.kind = KIND_REJECT;
		case (op)
			OP_INIT: begin
				for (int i = 0; i < NUM_TASKS; i++) stamp_q[i] = t;
				rr_base = 0;
				cur_off = 0;
				cur_task = 0;
				in_pass = 1'b0;
				v.kind = KIND_DONE;
			end
			OP_START: begin
				if (!in_pass) begin
					pass_t0 = t;
					v = scan_tasks(0, t);
				end
			end
			OP_DONE: begin
				if (in_pass) begin
					stamp_q[cur_task] = t;
					used = t - pass_t0;
					if (used >= {12'd0, budget_q}) begin
						rr_base = (cur_task + 1) % NUM_TASKS;
						in_pass = 1'b0;
						cur_off = 0;
						cur_task = 0;
						v.kind = KIND_DONE;
						v.spent = 1'b1;
					end else begin
						v = scan_tasks(cur_off + 1, t);
					end
				end
			end
			default: begin
			end
		endcase
		return v;
	endfunction

	function automatic logic [TIME_W-1:0] time_advance();
		case ($urandom_range(0, 9))
			0: return '0;
			1, 2, 3, 4, 5, 6: return TIME_W'($urandom_range(1, 600));
			7, 8: return TIME_W'($urandom_range(600, 5000));
			default: return TIME_W'($urandom_range(5000, 2000000));
		endcase
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint exp);
		$display("Mismatch in %s: got %0d, expected %0d at %0t", what, got, exp, $realtime);
		n_fail++;
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (outcome_q.size() == 0) begin
				report_mismatch("transaction with no outcome pending", m_tuser, 0);
			end else begin
				want = outcome_q.pop_front();
				if (m_tuser !== want.kind) report_mismatch("kind", m_tuser, want.kind);
				if (m_tdata[2:0] !== want.task_id)
					report_mismatch("task_index", m_tdata[2:0], want.task_id);
				if (m_tdata[3] !== want.spent)
					report_mismatch("budget_spent", m_tdata[3], want.spent);
				if (m_tdata[7:4] !== 4'd0) report_mismatch("zero fill", m_tdata[7:4], 0);
				if (want.kind == KIND_DISPATCH) n_dispatch++;
				if (want.spent) n_spent++;
				if (want.kind == KIND_REJECT) n_reject++;
			end
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if (jitter_on && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	task automatic send_item(input logic [1:0] op, input logic [TIME_W-1:0] t);
		if (jitter_on && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= t;
		do @(posedge clk); while (!s_tready);
		outcome_q.push_back(predict_dispatch(op, t));
		n_items++;
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		while (outcome_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [IVL_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_ENABLE) begin
			en_q = val[MASK_W-1:0];
		end else if (idx == CFG_BUDGET) begin
			budget_q = val;
		end else begin
			ivl_q[idx] = val;
		end
		n_cfg++;
	endtask

	task automatic program_registers();
		settle();
		for (int i = 0; i < NUM_TASKS; i++) cfg_write(CFG_IDX_W'(i), plan_ivl[i]);
		cfg_write(CFG_ENABLE, IVL_W'(plan_mask));
		cfg_write(CFG_BUDGET, plan_budget);
		cfg_valid <= 1'b0;
		n_phases++;
	endtask

	task automatic run_pass();
		now_us = now_us + time_advance();
		send_item(OP_START, now_us);
		while (in_pass) begin
			if ($urandom_range(0, 19) == 0) begin
				send_item(($urandom_range(0, 1) != 0) ? OP_START : OP_UNUSED, now_us);
			end
			now_us = now_us + time_advance();
			send_item(OP_DONE, now_us);
		end
	endtask

	task automatic random_traffic(input int unsigned count);
		int unsigned stop_at;
		int unsigned r;
		logic [1:0] op;
		stop_at = n_items + count;
		while (n_items < stop_at) begin
			r = $urandom_range(0, 99);
			if (r < 3) begin
				send_item(OP_INIT, now_us);
			end else if (r < 12) begin
				op = 2'($urandom_range(0, 3));
				if ($urandom_range(0, 1) != 0) now_us = $urandom;
				send_item(op, now_us);
			end else begin
				run_pass();
			end
		end
	endtask

	task automatic test_default_schedule();
		send_item(OP_START, 32'd200);
		send_item(OP_DONE, 32'd300);
		send_item(OP_START, 32'd1100);
		send_item(OP_DONE, 32'd1700);
		send_item(OP_START, 32'd1800);
		send_item(OP_DONE, 32'd1900);
	endtask

	task automatic test_rejections();
		send_item(OP_START, 32'd1950);
		send_item(OP_UNUSED, 32'hFFFF_FFFF);
		send_item(OP_INIT, 32'd2000);
		send_item(OP_DONE, 32'd2100);
		send_item(OP_UNUSED, 32'd0);
	endtask

	task automatic test_wraparound();
		send_item(OP_INIT, 32'hFFFF_FF00);
		send_item(OP_START, 32'h0000_0000);
		send_item(OP_DONE, 32'h0000_0300);
		send_item(OP_START, 32'hFFFF_FFFF);
	endtask

	task automatic test_register_extremes();
		plan_ivl = '{default: '0};
		plan_mask = 6'h3F;
		plan_budget = 20'hFFFFF;
		program_registers();
		send_item(OP_START, 32'd5000);
		for (int i = 0; i < NUM_TASKS; i++) send_item(OP_DONE, 32'd5001 + i);
		plan_mask = '0;
		program_registers();
		send_item(OP_START, 32'hFFFF_FFFF);
		plan_ivl = '{default: 20'hFFFFF};
		plan_mask = 6'h3F;
		plan_budget = '0;
		program_registers();
		send_item(OP_INIT, 32'd0);
		send_item(OP_START, 32'h000F_FFFE);
		send_item(OP_START, 32'h0010_0000);
		send_item(OP_DONE, 32'h0010_0000);
	endtask

	task automatic test_random_passes(input int unsigned count);
		int unsigned per_phase;
		per_phase = 150;
		for (int unsigned done_n = 0; done_n < count; done_n += per_phase) begin
			for (int i = 0; i < NUM_TASKS; i++) begin
				case ($urandom_range(0, 7))
					0: plan_ivl[i] = '0;
					1: plan_ivl[i] = 20'hFFFFF;
					default: plan_ivl[i] = IVL_W'($urandom_range(1, 3000));
				endcase
			end
			plan_mask = ($urandom_range(0, 2) == 0) ? 6'h3F : MASK_W'($urandom_range(0, 63));
			case ($urandom_range(0, 5))
				0: plan_budget = '0;
				1: plan_budget = 20'hFFFFF;
				default: plan_budget = IVL_W'($urandom_range(1, 4000));
			endcase
			program_registers();
			random_traffic(per_phase);
		end
	endtask

	task automatic test_full_rate(input int unsigned count);
		settle();
		jitter_on = 1'b0;
		plan_ivl = '{20'd125, 20'd1000, 20'd1000, 20'd1000, 20'd16666, 20'd2000};
		plan_mask = ENABLE_RESET;
		plan_budget = BUDGET_RESET;
		program_registers();
		random_traffic(count);
	endtask

	initial begin
		ivl_q = '{20'd125, 20'd1000, 20'd1000, 20'd1000, 20'd16666, 20'd2000};
		en_q = ENABLE_RESET;
		budget_q = BUDGET_RESET;
		stamp_q = '{default: '0};
		pass_t0 = '0;
		rr_base = 0;
		cur_off = 0;
		cur_task = 0;
		in_pass = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_schedule();
		test_rejections();
		test_wraparound();
		test_register_extremes();
		test_random_passes(1400);
		test_full_rate(400);
		settle();

		$display("Covered %0d events over %0d register settings (%0d register writes).",
			n_items, n_phases, n_cfg);
		$display("Seen: %0d dispatches, %0d passes ended on budget, %0d rejections.",
			n_dispatch, n_spent, n_reject);
		if (n_fail == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

/* files.f */
rtl/ptd_pkg.sv
rtl/ptd_cell.sv
rtl/ptd_ctrl.sv
rtl/periodic_task_dispatcher_core.sv
test/tb_periodic_task_dispatcher_core.sv
